[hw/rtl/tspe_pkg.sv]
// tspe_pkg: shared types and constants of the transport stream payload extractor
`default_nettype none

package tspe_pkg;

	// packet framing
	localparam int unsigned PacketBytes = 188;
	localparam logic [7:0]  PktLastPos  = 8'(PacketBytes - 1);
	localparam logic [7:0]  MaxAdaptLen = 8'(PacketBytes - 5);
	localparam logic [7:0]  PktEndOff   = 8'(PacketBytes);

	// header codes
	localparam logic [7:0]  SyncByte    = 8'h47;
	localparam int unsigned FlagUnitBit = 6;
	localparam int unsigned FlagAdaptBit = 5;
	localparam int unsigned FlagPayBit  = 4;
	localparam int unsigned PidWidth    = 13;

	// header byte positions
	localparam logic [7:0]  PosHunt     = 8'd0;
	localparam logic [7:0]  PosPidHigh  = 8'd1;
	localparam logic [7:0]  PosPidLow   = 8'd2;
	localparam logic [7:0]  PosFlags    = 8'd3;
	localparam logic [7:0]  PosAdaptLen = 8'd4;
	localparam logic [7:0]  NoAdaptOff  = 8'd4;
	localparam logic [7:0]  AdaptHdrLen = 8'd5;

	// one input transaction
	typedef struct packed {
		logic [7:0] stream_byte;
		logic       restart;
	} tspe_item_t;

	// one result transaction
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       unit_start;
		logic       packet_last;
	} tspe_result_t;

endpackage

`default_nettype wire

[hw/rtl/tspe_parser.sv]
// tspe_parser: packet position tracking, header parsing and payload selection
`default_nettype none

module tspe_parser (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  advance,
	input  wire tspe_pkg::tspe_item_t  item,
	input  wire logic [12:0]           target_pid,
	output logic                       emit,
	output tspe_pkg::tspe_result_t     result
);
	import tspe_pkg::*;

	// packet state
	logic [7:0] pos_q;
	logic       wait_q;
	logic [4:0] pid_hi_q;
	logic       usb_q;
	logic       sel_q;
	logic       ha_q;
	logic       hp_q;
	logic [7:0] off_q;
	logic       fpp_q;

	logic [7:0] pos_n;
	logic       wait_n;
	logic [4:0] pid_hi_n;
	logic       usb_n;
	logic       sel_n;
	logic       ha_n;
	logic       hp_n;
	logic [7:0] off_n;
	logic       fpp_n;
	logic [7:0] b;
	logic [7:0] cur_pos;
	logic       rs_do;
	logic [7:0] rs_off;

	assign b = item.stream_byte;

	// next state and result for one byte
	always_comb begin
		cur_pos  = pos_q;
		wait_n   = wait_q;
		pid_hi_n = pid_hi_q;
		usb_n    = usb_q;
		sel_n    = sel_q;
		ha_n     = ha_q;
		hp_n     = hp_q;
		off_n    = off_q;
		fpp_n    = fpp_q;
		rs_do    = 1'b0;
		rs_off   = NoAdaptOff;
		emit     = 1'b0;
		result.payload_byte = b;
		result.unit_start   = 1'b0;
		result.packet_last  = 1'b0;

		// restart clears the packet and arms the unit-start wait
		if (item.restart) begin
			cur_pos  = PosHunt;
			pid_hi_n = '0;
			usb_n    = 1'b0;
			sel_n    = 1'b0;
			ha_n     = 1'b0;
			hp_n     = 1'b0;
			off_n    = '0;
			fpp_n    = 1'b0;
			wait_n   = 1'b1;
		end
		pos_n = cur_pos;

		if (cur_pos == PosHunt) begin
			// sync hunt
			if (b == SyncByte) begin
				pid_hi_n = '0;
				usb_n    = 1'b0;
				sel_n    = 1'b0;
				ha_n     = 1'b0;
				hp_n     = 1'b0;
				off_n    = '0;
				fpp_n    = 1'b0;
				pos_n    = PosPidHigh;
			end
		end else begin
			// header fields
			if (cur_pos == PosPidHigh) begin
				pid_hi_n = b[4:0];
				usb_n    = b[FlagUnitBit];
			end else if (cur_pos == PosPidLow) begin
				sel_n = ({pid_hi_n, b} == target_pid);
			end else if (cur_pos == PosFlags) begin
				ha_n = b[FlagAdaptBit];
				hp_n = b[FlagPayBit];
				if (!hp_n) begin
					sel_n = 1'b0;
				end
				if (!ha_n) begin
					rs_do  = 1'b1;
					rs_off = NoAdaptOff;
				end
			end else if (cur_pos == PosAdaptLen && ha_n) begin
				if (b > MaxAdaptLen) begin
					sel_n = 1'b0;
					off_n = PktEndOff;
				end else begin
					rs_do  = 1'b1;
					rs_off = AdaptHdrLen + b;
				end
			end

			// payload start known: unit-start wait rule
			if (rs_do) begin
				off_n = rs_off;
				if (sel_n) begin
					if (wait_n) begin
						if (usb_n) begin
							wait_n = 1'b0;
						end else begin
							sel_n = 1'b0;
						end
					end
					fpp_n = sel_n;
				end
			end

			// position advance with wrap at the packet end
			pos_n = (cur_pos == PktLastPos) ? PosHunt : cur_pos + 8'd1;

			// payload byte out
			if (cur_pos >= PosAdaptLen && sel_n && hp_n && cur_pos >= off_n) begin
				emit = 1'b1;
				result.unit_start  = fpp_n && usb_n;
				result.packet_last = (cur_pos == PktLastPos);
				fpp_n = 1'b0;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			wait_q   <= 1'b0;
			pid_hi_q <= '0;
			usb_q    <= 1'b0;
			sel_q    <= 1'b0;
			ha_q     <= 1'b0;
			hp_q     <= 1'b0;
			off_q    <= '0;
			fpp_q    <= 1'b0;
		end else if (advance) begin
			pos_q    <= pos_n;
			wait_q   <= wait_n;
			pid_hi_q <= pid_hi_n;
			usb_q    <= usb_n;
			sel_q    <= sel_n;
			ha_q     <= ha_n;
			hp_q     <= hp_n;
			off_q    <= off_n;
			fpp_q    <= fpp_n;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/ts_payload_extractor_unit.sv]
// ts_payload_extractor_unit: top level of the transport stream payload extractor
//
// channel   direction  tdata / data           tuser       tlast
// s_*       in         [7:0] stream_byte      restart     -
// m_*       out        [7:0] payload_byte     unit_start  packet_last
// cfg_*     in         [12:0] target_pid      -           -
//
// one byte per clock while m_* does not stall: an input register feeds the parser,
// whose state update and payload decision are combinational into the output register
// a result passes the input register and then the output register
// a stall on m_* holds the output register and a full input register; the input
// side keeps accepting while the output register is empty or being taken
// reset clears packet state to sync hunt, target_pid to zero; no clearing pass
`default_nettype none

module ts_payload_extractor_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
	input  wire logic        s_tuser,   // [0] restart
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] payload_byte
	output logic             m_tuser,   // [0] unit_start
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [12:0] cfg_data
);
	import tspe_pkg::*;

	logic         in_valid_s1;
	tspe_item_t   in_item_s1;
	logic         out_valid_s2;
	tspe_result_t out_res_s2;
	logic         advance;
	logic         emit;
	tspe_result_t result;
	logic [PidWidth-1:0] target_pid_q;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_pid_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			target_pid_q <= cfg_data;
		end
	end

	// handshake control
	assign advance  = in_valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !in_valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_item_s1.stream_byte <= s_tdata;
			in_item_s1.restart     <= s_tuser;
		end
	end

	// parser
	tspe_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item       (in_item_s1),
		.target_pid (target_pid_q),
		.emit       (emit),
		.result     (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= emit;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_res_s2 <= result;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = out_res_s2.payload_byte;
	assign m_tuser  = out_res_s2.unit_start;
	assign m_tlast  = out_res_s2.packet_last;

	// an empty output register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

	// a taken result with nothing in the input register leaves no result behind
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !in_valid_s1) |=> !m_tvalid)
		else $error("result appeared without an input transaction");

	// a held input byte stays put until the parser takes it
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !advance) |=> (in_valid_s1 && $stable(in_item_s1)))
		else $error("input register changed while stalled");

endmodule

`default_nettype wire
